/* hdl/hta_pkg.sv */
// Shared types and codes for the hole table allocator.
`default_nettype none
package hta_pkg;

   // Operation codes carried on the request tuser.
   localparam logic [2:0] OP_ADD   = 3'd0;
   localparam logic [2:0] OP_ALLOC = 3'd1;
   localparam logic [2:0] OP_QUERY = 3'd2;
   localparam logic [2:0] OP_LIST  = 3'd3;
   localparam logic [2:0] OP_WIPE  = 3'd4;

   // Status codes carried on the response tuser.
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_TOO_SMALL = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_DUPLICATE = 3'd4;
   localparam logic [2:0] ST_EMPTY     = 3'd5;
   localparam logic [2:0] ST_NO_INIT   = 3'd6;

   localparam int BYTES_W = 21;
   localparam int WORD_W  = 16;
   localparam int WB_W    = 6;

   // Command broadcast to every cell of the hole chain.
   typedef enum logic [2:0] {
      CMD_HOLD      = 3'd0,
      CMD_ROTATE    = 3'd1,
      CMD_WR_PREV   = 3'd2,
      CMD_WR_PREV_DROP = 3'd3,
      CMD_WR_NEXT   = 3'd4,
      CMD_WR_EQ     = 3'd5,
      CMD_DROP_EQ   = 3'd6,
      CMD_INSERT    = 3'd7
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [WORD_W-1:0]   new_start;
      logic [WORD_W-1:0]   new_size;
   } cell_cmd_type;

   // Per-cell position flags relative to the request offset.
   typedef struct packed {
      logic le;
      logic is_prev;
      logic is_next;
      logic is_eq;
   } cell_flag_type;

endpackage
`default_nettype wire

/* hdl/hta_cell.sv */
// One cell of the hole chain: holds one hole and trades it with its neighbors.
`default_nettype none
module hta_cell
   import hta_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  wire logic                clock,
   input  wire logic [CNT_W-1:0]    count,
   input  wire logic [WORD_W-1:0]   offset,
   input  wire cell_cmd_type        cmd,
   input  wire logic [WORD_W-1:0]   left_start,
   input  wire logic [WORD_W-1:0]   left_size,
   input  wire logic                left_le,
   input  wire logic [WORD_W-1:0]   right_start,
   input  wire logic [WORD_W-1:0]   right_size,
   input  wire logic                right_le,
   output logic [WORD_W-1:0]        start,
   output logic [WORD_W-1:0]        size,
   output cell_flag_type            flags
);

   logic [WORD_W-1:0] start_ff, start_in;
   logic [WORD_W-1:0] size_ff, size_in;
   logic              le_ff, ge_ff, eq_ff;
   logic              valid;
   logic              at_p;

   assign valid = count > CNT_W'(INDEX);

   // Compare flags are registered; the table is stable while an op is decoded.
   always_ff @(posedge clock) begin
      le_ff <= valid && (start_ff <= offset);
      ge_ff <= start_ff >= offset;
      eq_ff <= valid && (start_ff == offset);
   end

   // This cell sits at the insert point when it is the first one past the offset.
   assign at_p = !le_ff && left_le;

   assign flags.le      = le_ff;
   assign flags.is_prev = le_ff && !right_le;
   assign flags.is_next = at_p && valid;
   assign flags.is_eq   = eq_ff;

   // Next contents of the cell.
   always_comb begin
      start_in = start_ff;
      size_in  = size_ff;
      case (cmd.kind)
         CMD_ROTATE: begin
            start_in = right_start;
            size_in  = right_size;
         end
         CMD_WR_PREV: begin
            if (flags.is_prev) size_in = cmd.new_size;
         end
         CMD_WR_PREV_DROP: begin
            if (flags.is_prev) begin
               size_in = cmd.new_size;
            end else if (!le_ff) begin
               start_in = right_start;
               size_in  = right_size;
            end
         end
         CMD_WR_NEXT: begin
            if (at_p) begin
               start_in = cmd.new_start;
               size_in  = cmd.new_size;
            end
         end
         CMD_WR_EQ: begin
            if (eq_ff) begin
               start_in = cmd.new_start;
               size_in  = cmd.new_size;
            end
         end
         CMD_DROP_EQ: begin
            if (ge_ff) begin
               start_in = right_start;
               size_in  = right_size;
            end
         end
         CMD_INSERT: begin
            if (at_p) begin
               start_in = cmd.new_start;
               size_in  = cmd.new_size;
            end else if (!le_ff) begin
               start_in = left_start;
               size_in  = left_size;
            end
         end
         default: begin
            start_in = start_ff;
            size_in  = size_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      size_ff  <= size_in;
   end

   assign start = start_ff;
   assign size  = size_ff;

endmodule
`default_nettype wire

/* hdl/hta_divider.sv */
// Bit-serial divider that rounds a byte count up to whole words.
`default_nettype none
module hta_divider
   import hta_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [BYTES_W-1:0]  dividend,
   input  wire logic [WB_W-1:0]     divisor,
   output logic                     done,
   output logic [BYTES_W-1:0]       quotient
);

   localparam int STEP_W = $clog2(BYTES_W + 1);

   logic [BYTES_W-1:0] quo_ff, quo_in;
   logic [WB_W-1:0]    rem_ff, rem_in;
   logic [WB_W-1:0]    div_ff, div_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [WB_W:0]      trial;

   // One quotient bit per cycle, restoring form.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      trial   = {rem_ff, quo_ff[BYTES_W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = (divisor == '0) ? WB_W'(1) : divisor;
         step_in = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            trial  = trial - {1'b0, div_ff};
            quo_in = {quo_ff[BYTES_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[BYTES_W-2:0], 1'b0};
         end
         rem_in  = trial[WB_W-1:0];
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(BYTES_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      step_ff <= step_in;
   end

   // Round up when anything is left over.
   assign done     = done_ff;
   assign quotient = quo_ff + BYTES_W'(rem_ff != '0);

endmodule
`default_nettype wire

/* hdl/hole_table_allocator.sv */
// Hole table allocator: a sorted chain of free holes with add, allocate, query, list, wipe.
//
// Usage:
//   Requests enter on req_* (tuser = op, tdata = offset and byte size). Each
//   request gives one response on rsp_*, except list, which gives one per held
//   hole with rsp_tlast on the final one; unknown ops are taken and dropped.
//   csr_wr_en/csr_wr_data set the bytes per word; the user must write them only
//   while the block is idle, as the block itself does not enforce it.
// Sequencing:
//   Add, allocate, query and wipe first pass the byte size through the 21-step
//   byte-to-word divider. A list walks the chain by rotating it one cell a cycle,
//   MAX_HOLES cells in all, one response per cycle while the receiver keeps
//   up; an empty list gives a single status response. One request is in work at a
//   time; req_tready is high only between requests.
// Reset:
//   Synchronous reset empties the table, clears the initialized mark and sets
//   the word size to 8 bytes. No clearing pass is needed.
// Stalls:
//   A response waits in the output register while rsp_tready is low; no new
//   response loads until it is taken, and the chain moves only to end a list's turn.
`default_nettype none
module hole_table_allocator
   import hta_pkg::*;
#(
   parameter int MAX_HOLES = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // Request channel.
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [39:0]  req_tdata,   // [15:0] offset_words, [36:16] size_bytes
   input  wire logic [2:0]   req_tuser,   // [2:0] op
   // Response channel.
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [15:0] offset_words_res, [31:16] size_words, [52:32] size_bytes_out,
   // [57:53] hole_count
   output logic [63:0]       rsp_tdata,
   output logic [2:0]        rsp_tuser,   // [2:0] status
   output logic              rsp_tlast,
   // Word size register.
   input  wire logic         csr_wr_en,
   input  wire logic [5:0]   csr_wr_data
);

   localparam int CNT_W = $clog2(MAX_HOLES + 1);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_DIV  = 5'b00010,
      S_EXEC = 5'b00100,
      S_LIST = 5'b01000,
      S_SPIN = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 init_ff, init_in;
   logic [CNT_W-1:0]     step_ff, step_in;
   logic [WB_W-1:0]      wb_ff;
   logic [WB_W-1:0]      wb_eff;
   logic [2:0]           op_ff;
   logic [WORD_W-1:0]    off_ff;
   logic [BYTES_W-1:0]   bytes_ff;

   logic                 div_start, div_done;
   logic [BYTES_W-1:0]   q;

   cell_cmd_type         cmd;
   logic [WORD_W-1:0]    cell_start [MAX_HOLES];
   logic [WORD_W-1:0]    cell_size  [MAX_HOLES];
   cell_flag_type        cell_flags [MAX_HOLES];

   // Gathered neighbor information, registered.
   logic                 has_prev_ff, has_next_ff, found_ff;
   logic [WORD_W-1:0]    ps_ff, psz_ff, ns_ff, nsz_ff, hsz_ff;
   logic                 has_prev_g, has_next_g, found_g;
   logic [WORD_W-1:0]    ps_g, psz_g, ns_g, nsz_g, hsz_g;

   // Response register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           rsp_status_ff;
   logic [WORD_W-1:0]    rsp_off_ff, rsp_sw_ff;
   logic [BYTES_W-1:0]   rsp_sb_ff;
   logic [4:0]           rsp_cnt_ff;
   logic                 rsp_last_ff;
   logic                 rsp_free;
   logic                 ld, ld_last;
   logic [2:0]           ld_status;
   logic [WORD_W-1:0]    ld_off, ld_sw;
   logic [21:0]          ld_prod;
   logic [31:0]          cnt_wide;

   // Execution decode.
   logic [2:0]           ex_status;
   logic [WORD_W-1:0]    ex_off, ex_sw;
   logic [CNT_W-1:0]     ex_cnt;
   logic                 ex_init;
   cell_cmd_type         ex_cmd;
   logic [16:0]          lim, s1, prev_end, add_end, jl_sum, both_sum, jr_sum;
   logic [WORD_W-1:0]    sz;
   logic                 dup, join_l, join_r;

   logic                 req_acc;

   assign wb_eff     = (wb_ff == '0) ? WB_W'(1) : wb_ff;
   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // Word size register.
   always_ff @(posedge clock) begin
      if (reset) begin
         wb_ff <= WB_W'(8);
      end else if (csr_wr_en) begin
         wb_ff <= csr_wr_data;
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         op_ff    <= req_tuser;
         off_ff   <= req_tdata[15:0];
         bytes_ff <= req_tdata[36:16];
      end
   end

   assign div_start = req_acc && (req_tuser != OP_LIST) && (req_tuser <= OP_WIPE);

   hta_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_tdata[36:16]),
      .divisor  (wb_ff),
      .done     (div_done),
      .quotient (q)
   );

   // Chain of hole cells.
   for (genvar i = 0; i < MAX_HOLES; i++) begin : g_cell
      logic [WORD_W-1:0] l_start, l_size, r_start, r_size;
      logic              l_le, r_le;
      if (i == 0) begin : g_first
         assign l_start = cell_start[0];
         assign l_size  = cell_size[0];
         assign l_le    = 1'b1;
      end else begin : g_mid_l
         assign l_start = cell_start[i-1];
         assign l_size  = cell_size[i-1];
         assign l_le    = cell_flags[i-1].le;
      end
      if (i == MAX_HOLES - 1) begin : g_last
         assign r_start = cell_start[0];
         assign r_size  = cell_size[0];
         assign r_le    = 1'b0;
      end else begin : g_mid_r
         assign r_start = cell_start[i+1];
         assign r_size  = cell_size[i+1];
         assign r_le    = cell_flags[i+1].le;
      end
      hta_cell #(.INDEX(i), .CNT_W(CNT_W)) u_cell (
         .clock       (clock),
         .count       (count_ff),
         .offset      (off_ff),
         .cmd         (cmd),
         .left_start  (l_start),
         .left_size   (l_size),
         .left_le     (l_le),
         .right_start (r_start),
         .right_size  (r_size),
         .right_le    (r_le),
         .start       (cell_start[i]),
         .size        (cell_size[i]),
         .flags       (cell_flags[i])
      );
   end

   // Collect the neighbors of the offset and the hole that starts there.
   always_comb begin
      has_prev_g = 1'b0;
      has_next_g = 1'b0;
      found_g    = 1'b0;
      ps_g  = '0;
      psz_g = '0;
      ns_g  = '0;
      nsz_g = '0;
      hsz_g = '0;
      for (int i = 0; i < MAX_HOLES; i++) begin
         has_prev_g = has_prev_g | cell_flags[i].is_prev;
         has_next_g = has_next_g | cell_flags[i].is_next;
         found_g    = found_g | cell_flags[i].is_eq;
         ps_g  = ps_g  | (cell_start[i] & {WORD_W{cell_flags[i].is_prev}});
         psz_g = psz_g | (cell_size[i]  & {WORD_W{cell_flags[i].is_prev}});
         ns_g  = ns_g  | (cell_start[i] & {WORD_W{cell_flags[i].is_next}});
         nsz_g = nsz_g | (cell_size[i]  & {WORD_W{cell_flags[i].is_next}});
         hsz_g = hsz_g | (cell_size[i]  & {WORD_W{cell_flags[i].is_eq}});
      end
   end

   always_ff @(posedge clock) begin
      has_prev_ff <= has_prev_g;
      has_next_ff <= has_next_g;
      found_ff    <= found_g;
      ps_ff  <= ps_g;
      psz_ff <= psz_g;
      ns_ff  <= ns_g;
      nsz_ff <= nsz_g;
      hsz_ff <= hsz_g;
   end

   // Decode of a single-response operation.
   always_comb begin
      ex_status = ST_OK;
      ex_off    = '0;
      ex_sw     = '0;
      ex_cnt    = count_ff;
      ex_init   = init_ff;
      ex_cmd.kind      = CMD_HOLD;
      ex_cmd.new_start = '0;
      ex_cmd.new_size  = '0;
      lim      = 17'h10000 - {1'b0, off_ff};
      s1       = (q > {4'b0, lim}) ? lim : q[16:0];
      sz       = s1[16] ? 16'hFFFF : s1[15:0];
      prev_end = {1'b0, ps_ff} + {1'b0, psz_ff};
      add_end  = {1'b0, off_ff} + {1'b0, sz};
      jl_sum   = {1'b0, psz_ff} + {1'b0, sz};
      both_sum = {1'b0, jl_sum[15:0]} + {1'b0, nsz_ff};
      jr_sum   = {1'b0, nsz_ff} + {1'b0, sz};
      dup      = (has_prev_ff && prev_end > {1'b0, off_ff}) ||
                 (has_next_ff && add_end > {1'b0, ns_ff});
      join_l   = has_prev_ff && prev_end == {1'b0, off_ff} && !jl_sum[16];
      join_r   = has_next_ff && add_end == {1'b0, ns_ff};
      case (op_ff)
         OP_ADD: begin
            ex_init = 1'b1;
            if (q != '0) begin
               if (dup) begin
                  ex_status = ST_DUPLICATE;
               end else if (join_l) begin
                  if (join_r && !both_sum[16]) begin
                     ex_cmd.kind     = CMD_WR_PREV_DROP;
                     ex_cmd.new_size = both_sum[15:0];
                     ex_cnt          = count_ff - CNT_W'(1);
                  end else begin
                     ex_cmd.kind     = CMD_WR_PREV;
                     ex_cmd.new_size = jl_sum[15:0];
                  end
               end else if (join_r && !jr_sum[16]) begin
                  ex_cmd.kind      = CMD_WR_NEXT;
                  ex_cmd.new_start = off_ff;
                  ex_cmd.new_size  = jr_sum[15:0];
               end else if (count_ff >= CNT_W'(MAX_HOLES)) begin
                  ex_status = ST_FULL;
               end else begin
                  ex_cmd.kind      = CMD_INSERT;
                  ex_cmd.new_start = off_ff;
                  ex_cmd.new_size  = sz;
                  ex_cnt           = count_ff + CNT_W'(1);
               end
            end
         end
         OP_ALLOC: begin
            if (!found_ff) begin
               ex_status = ST_NOT_FOUND;
            end else if (q > {5'b0, hsz_ff}) begin
               ex_status = ST_TOO_SMALL;
            end else begin
               ex_off = off_ff;
               ex_sw  = q[15:0];
               if (q[15:0] == hsz_ff) begin
                  ex_cmd.kind = CMD_DROP_EQ;
                  ex_cnt      = count_ff - CNT_W'(1);
               end else if (q != '0) begin
                  ex_cmd.kind      = CMD_WR_EQ;
                  ex_cmd.new_start = off_ff + q[15:0];
                  ex_cmd.new_size  = hsz_ff - q[15:0];
               end
            end
         end
         OP_QUERY: begin
            if (!found_ff) begin
               ex_status = ST_NOT_FOUND;
            end else begin
               ex_off = off_ff;
               ex_sw  = hsz_ff;
            end
         end
         OP_LIST: begin
            ex_status = init_ff ? ST_EMPTY : ST_NO_INIT;
         end
         OP_WIPE: begin
            ex_cnt  = '0;
            ex_init = 1'b0;
         end
         default: begin
            ex_status = ST_OK;
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      init_in   = init_ff;
      step_in   = step_ff;
      cmd.kind      = CMD_HOLD;
      cmd.new_start = '0;
      cmd.new_size  = '0;
      ld        = 1'b0;
      ld_status = ST_OK;
      ld_off    = '0;
      ld_sw     = '0;
      ld_last   = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               step_in = '0;
               if (req_tuser == OP_LIST) begin
                  state_in = (init_ff && count_ff != '0) ? S_LIST : S_EXEC;
               end else if (req_tuser <= OP_WIPE) begin
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_done) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (rsp_free) begin
               ld        = 1'b1;
               ld_status = ex_status;
               ld_off    = ex_off;
               ld_sw     = ex_sw;
               cmd       = ex_cmd;
               count_in  = ex_cnt;
               init_in   = ex_init;
               state_in  = S_IDLE;
            end
         end
         S_LIST: begin
            // Emit the head cell and rotate the chain by one.
            if (rsp_free) begin
               ld       = 1'b1;
               ld_off   = cell_start[0];
               ld_sw    = cell_size[0];
               ld_last  = (step_ff + CNT_W'(1)) == count_ff;
               cmd.kind = CMD_ROTATE;
               step_in  = step_ff + CNT_W'(1);
               if ((step_ff + CNT_W'(1)) == CNT_W'(MAX_HOLES)) begin
                  state_in = S_IDLE;
               end else if (ld_last) begin
                  state_in = S_SPIN;
               end
            end
         end
         S_SPIN: begin
            // Finish the full turn so the chain returns to sorted order.
            cmd.kind = CMD_ROTATE;
            step_in  = step_ff + CNT_W'(1);
            if ((step_ff + CNT_W'(1)) == CNT_W'(MAX_HOLES)) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         init_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         init_ff  <= init_in;
         step_ff  <= step_in;
      end
   end

   // Response register.
   assign rsp_valid_in = ld || (rsp_valid_ff && !rsp_tready);
   assign ld_prod      = ld_sw * wb_eff;
   assign cnt_wide     = 32'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (ld) begin
         rsp_status_ff <= ld_status;
         rsp_off_ff    <= ld_off;
         rsp_sw_ff     <= ld_sw;
         rsp_sb_ff     <= ld_prod[BYTES_W-1:0];
         rsp_cnt_ff    <= cnt_wide[4:0];
         rsp_last_ff   <= ld_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {6'b0, rsp_cnt_ff, rsp_sb_ff, rsp_sw_ff, rsp_off_ff};

   // Checks on the sequencer and the table count.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_HOLES))
      else $error("hole count exceeds table depth");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state is not one-hot");

   a_list_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LIST) |-> (count_ff != '0))
      else $error("list walk started on an empty table");

   a_chain_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_DIV) |-> (cmd.kind == CMD_HOLD))
      else $error("chain changed outside an update");

endmodule
`default_nettype wire
